FILE: design/mmfn_pkg.sv
// Package for the min-max feature normaliser: sizes, action and status codes,
// and the record passed from the front end to the divider back end.
// No dependencies.
`default_nettype none
package mmfn_pkg;
    localparam int MAX_VALUES   = 8192;
    localparam int MAX_FEATURES = 8;
    localparam int ADDR_W  = $clog2(MAX_VALUES);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int COL_W   = $clog2(MAX_FEATURES);
    localparam int FC_W    = 4;
    localparam int QUO_W   = 17;
    localparam int DIFF_W  = 33;
    localparam int QDEPTH  = 2;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    // Kinds of work handed to the back end
    typedef enum logic [1:0] {
        JOB_IMM  = 2'd0,  // result fully known, pass straight out
        JOB_DIV  = 2'd1,  // needs a quotient
        JOB_READ = 2'd2   // store value pending, compare and maybe divide
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [1:0]          status;
        logic                last;
        logic [QUO_W-1:0]    imm;
        logic signed [31:0]  lo;
        logic signed [31:0]  hi;
        logic [ADDR_W-1:0]   addr;
    } job_t;
endpackage
`default_nettype wire

FILE: design/mmfn_front.sv
// Front end: takes commands, keeps counts, column min/max and the value store,
// and pushes one job word per command into the queue. Uses mmfn_pkg.
`default_nettype none
module mmfn_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  take,
    input  wire logic [1:0]            action,
    input  wire logic signed [31:0]    sample_value,
    input  wire logic [3:0]            fc_raw,
    input  wire logic                  rd_en,
    input  wire logic [mmfn_pkg::ADDR_W-1:0] rd_addr,
    output logic                       push,
    output mmfn_pkg::job_t             job,
    output logic signed [31:0]         rd_data
);
    logic [31:0]                     mem [mmfn_pkg::MAX_VALUES];
    logic signed [31:0]              min_reg [mmfn_pkg::MAX_FEATURES];
    logic signed [31:0]              max_reg [mmfn_pkg::MAX_FEATURES];
    logic [mmfn_pkg::MAX_FEATURES-1:0] seen_reg;
    logic [mmfn_pkg::CNT_W-1:0]      cnt_reg, dpos_reg;
    logic [mmfn_pkg::COL_W-1:0]      lcol_reg, dcol_reg;
    logic                            draining_reg;
    logic [mmfn_pkg::FC_W-1:0]       fc;
    logic [mmfn_pkg::COL_W-1:0]      lcol, dcol, lcol_next, dcol_next;
    logic                            do_load, do_read;
    logic signed [31:0]              cur_min, cur_max;

    // Clamp feature count to 1..MAX_FEATURES
    always_comb
    begin
        if (fc_raw == '0)
            fc = mmfn_pkg::FC_W'(1);
        else if (fc_raw > mmfn_pkg::FC_W'(mmfn_pkg::MAX_FEATURES))
            fc = mmfn_pkg::FC_W'(mmfn_pkg::MAX_FEATURES);
        else
            fc = fc_raw;
    end

    // Column of next load and drain, with wrap
    always_comb
    begin
        lcol = ({1'b0, lcol_reg} < fc) ? lcol_reg : '0;
        dcol = ({1'b0, dcol_reg} < fc) ? dcol_reg : '0;
        lcol_next = ({1'b0, lcol} + 4'd1 >= fc) ? '0 : lcol + 1'b1;
        dcol_next = ({1'b0, dcol} + 4'd1 >= fc) ? '0 : dcol + 1'b1;
        do_load = take && action == mmfn_pkg::ACT_LOAD && !draining_reg
                  && cnt_reg < mmfn_pkg::CNT_W'(mmfn_pkg::MAX_VALUES);
        do_read = take && action == mmfn_pkg::ACT_DRAIN && dpos_reg < cnt_reg;
        cur_min = seen_reg[dcol] ? min_reg[dcol] : '0;
        cur_max = seen_reg[dcol] ? max_reg[dcol] : '0;
    end

    // Value store: one write, one registered read at the back end's address.
    // A drain word carries its address and is read when popped; the queue is
    // only two deep, so a later clear and reload cannot reach that entry first.
    always_ff @(posedge clk)
    begin
        if (do_load)
            mem[cnt_reg[mmfn_pkg::ADDR_W-1:0]] <= sample_value;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    // Column extremes
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            if (!seen_reg[lcol] || sample_value < min_reg[lcol])
                min_reg[lcol] <= sample_value;
            if (!seen_reg[lcol] || sample_value > max_reg[lcol])
                max_reg[lcol] <= sample_value;
        end
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0; cnt_reg <= '0; dpos_reg <= '0;
            lcol_reg <= '0; dcol_reg <= '0; draining_reg <= 1'b0;
        end
        else if (take)
        begin
            case (action)
                mmfn_pkg::ACT_CLEAR:
                begin
                    seen_reg <= '0; cnt_reg <= '0; dpos_reg <= '0;
                    lcol_reg <= '0; dcol_reg <= '0; draining_reg <= 1'b0;
                end
                mmfn_pkg::ACT_LOAD:
                    if (do_load)
                    begin
                        seen_reg[lcol] <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                        lcol_reg <= lcol_next;
                    end
                mmfn_pkg::ACT_DRAIN:
                begin
                    draining_reg <= 1'b1;
                    if (do_read)
                    begin
                        dpos_reg <= dpos_reg + 1'b1;
                        dcol_reg <= dcol_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Build the job word
    always_comb
    begin
        push = take;
        job = '0;
        job.kind = mmfn_pkg::JOB_IMM;
        case (action)
            mmfn_pkg::ACT_LOAD:
                if (draining_reg)
                    job.status = mmfn_pkg::ST_REJECT;
                else if (!do_load)
                    job.status = mmfn_pkg::ST_FULL;
            mmfn_pkg::ACT_DRAIN:
                if (!do_read)
                    job.status = mmfn_pkg::ST_EMPTY;
                else
                begin
                    job.kind = mmfn_pkg::JOB_READ;
                    job.last = (dpos_reg + 1'b1 == cnt_reg);
                    job.lo = cur_min;
                    job.hi = cur_max;
                    job.addr = dpos_reg[mmfn_pkg::ADDR_W-1:0];
                end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/mmfn_queue.sv
// Two-entry job queue between front end and back end. Uses mmfn_pkg.
`default_nettype none
module mmfn_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mmfn_pkg::job_t  din,
    input  wire logic            pop,
    output mmfn_pkg::job_t       dout,
    output logic                 empty,
    output logic                 full
);
    mmfn_pkg::job_t slot_reg [mmfn_pkg::QDEPTH];
    logic           wp_reg, rp_reg;
    logic [1:0]     n_reg;

    assign dout  = slot_reg[rp_reg];
    assign empty = n_reg == 2'd0;
    assign full  = n_reg == 2'd2;

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= din;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; n_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            n_reg <= n_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg != 2'd3) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

FILE: design/mmfn_back.sv
// Back end: pops jobs, clamps against min/max and runs a restoring divider
// one quotient bit per cycle, then strobes the result. Uses mmfn_pkg.
`default_nettype none
module mmfn_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  wire mmfn_pkg::job_t       job,
    input  wire logic signed [31:0]   rd_data,
    output logic                      pop,
    output logic                      rd_en,
    output logic [mmfn_pkg::ADDR_W-1:0] rd_addr,
    output logic                      done,
    output logic [16:0]               normalized_value,
    output logic                      last_value,
    output logic [1:0]                status
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [mmfn_pkg::DIFF_W-1:0]     rem_reg, den_reg;
    logic [mmfn_pkg::QUO_W-1:0]      quo_reg;
    logic [4:0]                      bit_reg;
    logic                            last_reg;
    logic [1:0]                      st_reg;
    logic signed [31:0]              lo_reg, hi_reg;
    logic [mmfn_pkg::DIFF_W:0]       trial;
    logic                            pop_read;

    assign trial = {rem_reg, 1'b0} - {1'b0, den_reg};
    assign pop_read = state_reg == S_IDLE && !empty;
    assign pop = pop_read;

    // Fetch the stored value as a drain word leaves the queue
    assign rd_en = pop_read && job.kind == mmfn_pkg::JOB_READ;
    assign rd_addr = job.addr;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (!empty)
                    state_next = (job.kind == mmfn_pkg::JOB_READ) ? S_READ : S_OUT;
            S_READ:
                if (hi_reg > lo_reg && rd_data > lo_reg && rd_data < hi_reg)
                    state_next = S_DIV;
                else
                    state_next = S_OUT;
            S_DIV:
                if (bit_reg == 5'd0) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (!empty)
                begin
                    quo_reg  <= job.imm;
                    last_reg <= job.last;
                    st_reg   <= job.status;
                    lo_reg   <= job.lo;
                    hi_reg   <= job.hi;
                end
            S_READ:
            begin
                rem_reg <= mmfn_pkg::DIFF_W'({rd_data[31], rd_data}
                           - {lo_reg[31], lo_reg});
                den_reg <= mmfn_pkg::DIFF_W'({hi_reg[31], hi_reg}
                           - {lo_reg[31], lo_reg});
                bit_reg <= 5'd15;
                if (hi_reg > lo_reg && rd_data >= hi_reg)
                    quo_reg <= 17'h10000;
                else
                    quo_reg <= '0;
            end
            S_DIV:
            begin
                // num < den so first quotient bit is 0; 16 fraction bits here
                if (!trial[mmfn_pkg::DIFF_W])
                begin
                    rem_reg <= trial[mmfn_pkg::DIFF_W-1:0];
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[mmfn_pkg::DIFF_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                bit_reg <= bit_reg - 5'd1;
            end
            default: ;
        endcase
    end

    // Drive result for one cycle
    assign done = state_reg == S_OUT;
    assign normalized_value = done ? quo_reg : '0;
    assign last_value = done & last_reg;
    assign status = done ? st_reg : '0;

`ifndef ASSERT_OFF
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normalized_value <= 17'h10000) else $error("result above one");
`endif
endmodule
`default_nettype wire

FILE: design/min_max_feature_normalizer.sv
// Top level of the min-max feature normaliser.
// Instantiates mmfn_front, mmfn_queue and mmfn_back; uses mmfn_pkg.
//
// Usage: raise start with action and sample_value while busy is low; the
// word is taken on that edge. Action clear empties the dataset, load stores a
// signed Q16.16 value (column = load position modulo feature_count), drain
// returns the next stored value as (value-min)/(max-min) in Q1.16.
// Each command yields one result word, shown for one cycle with done high:
// normalized_value, last_value and status.
// Clear, load, unused code and an empty drain go from S_IDLE to S_OUT; a
// drain that needs no division also passes S_READ, a dividing drain S_READ
// and S_DIV, where the restoring divider makes one quotient bit per cycle.
// The back end pops a word only in S_IDLE, so it works on one word at a time;
// words wait in the queue. busy is high while the job queue is full; up to
// two commands can wait. feature_count is written with cfg_we/cfg_data; the
// user must do so only when idle, as the block does not enforce it. Reset
// sets it to 1 and empties the dataset and queue; no clearing pass is needed
// as the store is read only below the fill count. The receiver cannot stall.
`default_nettype none
module min_max_feature_normalizer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [3:0]         cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] sample_value,
    output logic                    done,
    output logic [16:0]             normalized_value,
    output logic                    last_value,
    output logic [1:0]              status
);
    logic [3:0]          fc_reg;
    logic                take, push, pop, empty, full;
    mmfn_pkg::job_t      job_in, job_out;
    logic signed [31:0]  rd_data;
    logic                rd_en;
    logic [mmfn_pkg::ADDR_W-1:0] rd_addr;

    assign busy = full;
    assign take = start && !busy;

    // Hold feature count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fc_reg <= 4'd1;
        else if (cfg_we)
            fc_reg <= cfg_data;
    end

    mmfn_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .action(action),
        .sample_value(sample_value), .fc_raw(fc_reg),
        .rd_en(rd_en), .rd_addr(rd_addr),
        .push(push), .job(job_in), .rd_data(rd_data)
    );

    mmfn_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(job_in),
        .pop(pop), .dout(job_out), .empty(empty), .full(full)
    );

    mmfn_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .job(job_out),
        .rd_data(rd_data), .pop(pop), .rd_en(rd_en), .rd_addr(rd_addr),
        .done(done), .normalized_value(normalized_value),
        .last_value(last_value), .status(status)
    );
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for min_max_feature_normalizer: random and directed commands,
// a built-in normaliser model, and a result checker on done.
// Depends on mmfn_pkg and the design sources.
`default_nettype none
module tb_top;
    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] val;
    } cmd_t;

    typedef struct packed {
        logic [16:0] norm;
        logic        last;
        logic [1:0]  stat;
    } word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [3:0]         cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic signed [31:0] sample_value;
    logic               done;
    logic [16:0]        normalized_value;
    logic               last_value;
    logic [1:0]         status;

    min_max_feature_normalizer dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .action(action), .sample_value(sample_value),
        .done(done), .normalized_value(normalized_value),
        .last_value(last_value), .status(status)
    );

    // Model state
    logic [31:0]        store_m [mmfn_pkg::MAX_VALUES];
    logic signed [31:0] col_min [mmfn_pkg::MAX_FEATURES];
    logic signed [31:0] col_max [mmfn_pkg::MAX_FEATURES];
    logic               col_seen [mmfn_pkg::MAX_FEATURES];
    int unsigned        n_loaded, drain_pos, load_col, drain_col, feat_cnt;
    bit                 in_drain;

    cmd_t  pending_cmds [$];
    word_t expected_words [$];
    int    errors;
    int    burst_left, gap_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_dataset();
        for (int i = 0; i < mmfn_pkg::MAX_FEATURES; i++)
        begin
            col_min[i] = 0;
            col_max[i] = 0;
            col_seen[i] = 1'b0;
        end
        n_loaded = 0;
        drain_pos = 0;
        load_col = 0;
        drain_col = 0;
        in_drain = 1'b0;
    endfunction

    function automatic int unsigned step_col(ref int unsigned ctr, input int unsigned fc);
        int unsigned c;
        c = (ctr < fc) ? ctr : 0;
        ctr = (c + 1 >= fc) ? 0 : c + 1;
        return c;
    endfunction

    // Work out the result word for one accepted command
    function automatic word_t normalise_cmd(cmd_t c);
        word_t w;
        int unsigned fc, col;
        logic signed [31:0] v, lo, hi;
        longint num, den;
        w = '0;
        fc = (feat_cnt == 0) ? 1 :
             (feat_cnt > mmfn_pkg::MAX_FEATURES ? mmfn_pkg::MAX_FEATURES : feat_cnt);
        if (c.act == mmfn_pkg::ACT_CLEAR)
            clear_dataset();
        else if (c.act == mmfn_pkg::ACT_LOAD)
        begin
            if (in_drain)
                w.stat = mmfn_pkg::ST_REJECT;
            else if (n_loaded >= mmfn_pkg::MAX_VALUES)
                w.stat = mmfn_pkg::ST_FULL;
            else
            begin
                v = c.val;
                col = step_col(load_col, fc);
                store_m[n_loaded] = c.val;
                if (!col_seen[col])
                begin
                    col_seen[col] = 1'b1;
                    col_min[col] = v;
                    col_max[col] = v;
                end
                else
                begin
                    if (v < col_min[col]) col_min[col] = v;
                    if (v > col_max[col]) col_max[col] = v;
                end
                n_loaded++;
            end
        end
        else if (c.act == mmfn_pkg::ACT_DRAIN)
        begin
            in_drain = 1'b1;
            if (drain_pos >= n_loaded)
                w.stat = mmfn_pkg::ST_EMPTY;
            else
            begin
                v = store_m[drain_pos];
                col = step_col(drain_col, fc);
                lo = col_min[col];
                hi = col_max[col];
                if (hi > lo)
                begin
                    if (v <= lo)
                        w.norm = 0;
                    else if (v >= hi)
                        w.norm = 17'd65536;
                    else
                    begin
                        den = longint'(hi) - longint'(lo);
                        num = longint'(v) - longint'(lo);
                        w.norm = 17'((num * 65536) / den);
                    end
                end
                w.last = (drain_pos + 1 == n_loaded);
                drain_pos++;
            end
        end
        return w;
    endfunction

    // Drive commands in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            start <= 1'b0;
            action <= mmfn_pkg::ACT_CLEAR;
            sample_value <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                expected_words.push_back(normalise_cmd({action, sample_value}));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    c = pending_cmds.pop_front();
                    start <= 1'b1;
                    action <= c.act;
                    sample_value <= c.val;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word norm=%0d last=%0d status=%0d",
                         $time, normalized_value, last_value, status);
                errors++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (w.norm !== normalized_value || w.last !== last_value
                    || w.stat !== status)
                begin
                    $display({"%0t: mismatch expected norm=%0d last=%0d status=%0d,",
                              " got norm=%0d last=%0d status=%0d"},
                             $time, w.norm, w.last, w.stat,
                             normalized_value, last_value, status);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] a, logic [31:0] v);
        pending_cmds.push_back({a, v});
    endtask

    // Wait for all queued work to come back, then let the divider settle
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_count(logic [3:0] fc);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= fc;
        @(posedge clk);
        cfg_we <= 1'b0;
        feat_cnt = fc;
    endtask

    initial
    begin
        int n, rows;
        logic [3:0] fc;
        errors = 0;
        feat_cnt = 1;
        clear_dataset();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        action = mmfn_pkg::ACT_CLEAR;
        sample_value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty drain, extremes, reject, unused code
        push_cmd(mmfn_pkg::ACT_DRAIN, 0);
        push_cmd(mmfn_pkg::ACT_LOAD, 1);
        push_cmd(mmfn_pkg::ACT_CLEAR, 0);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'h8000_0000);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'h7FFF_FFFF);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'h0000_0000);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++) push_cmd(mmfn_pkg::ACT_DRAIN, 0);
        push_cmd(mmfn_pkg::ACT_LOAD, 5);
        push_cmd(2'd3, 32'hFFFF_FFFF);
        push_cmd(mmfn_pkg::ACT_CLEAR, 0);
        wait_idle();

        // Two columns, then shrink the count mid-load to push values outside range
        write_count(4'd2);
        for (int i = 0; i < 5; i++) push_cmd(mmfn_pkg::ACT_LOAD, rand_value());
        wait_idle();
        write_count(4'd1);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'h7FFF_FFFF);
        push_cmd(mmfn_pkg::ACT_LOAD, 32'h8000_0000);
        wait_idle();
        write_count(4'd3);
        for (int i = 0; i < 8; i++) push_cmd(mmfn_pkg::ACT_DRAIN, 0);
        push_cmd(mmfn_pkg::ACT_CLEAR, 0);
        wait_idle();

        // Random phases: mostly load-then-drain datasets, some noise
        n = 0;
        while (n < 500)
        begin
            case ($urandom_range(0, 5))
                0: fc = 4'd0;
                1: fc = 4'd15;
                2: fc = 4'd8;
                default: fc = 4'($urandom_range(1, 9));
            endcase
            write_count(fc);
            for (int s = 0; s < 4; s++)
            begin
                rows = $urandom_range(1, 6);
                for (int i = 0; i < rows * $urandom_range(1, 8); i++)
                begin
                    push_cmd($urandom_range(0, 30) == 0 ?
                             2'($urandom_range(0, 3)) : mmfn_pkg::ACT_LOAD,
                             rand_value());
                    n++;
                end
                for (int i = 0; i < rows * 4 + 2; i++)
                begin
                    push_cmd($urandom_range(0, 30) == 0 ?
                             2'($urandom_range(0, 3)) : mmfn_pkg::ACT_DRAIN,
                             rand_value());
                    n++;
                end
                push_cmd(mmfn_pkg::ACT_CLEAR, 0);
                n++;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung run
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
